// ===== rtl/core/wlru_pkg.sv =====
// ----------------------------------------------------------------------------
// wlru_pkg
// Shared types and constants of the weighted lru cache evictor.
// ----------------------------------------------------------------------------
package wlru_pkg;

  localparam int unsigned DefEntries = 16;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned WeightW = 17;
  localparam int unsigned MaxW    = 16;
  localparam int unsigned FracW   = 9;

  localparam logic [MaxW-1:0]  MaxSizeRst = 16'd1024;
  localparam logic [FracW-1:0] FracRst    = 9'd192;
  localparam logic [FracW-1:0] FracFull   = 9'd256;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TRIM   = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_EVICTED  = 3'd0,
    ST_STORED   = 3'd1,
    ST_REJECTED = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_ABSENT   = 3'd4,
    ST_TRIMMED  = 3'd5
  } status_e;

  typedef enum logic {
    CFG_MAX_SIZE   = 1'b0,
    CFG_CLEAN_FRAC = 1'b1
  } cfg_idx_e;

endpackage

// ===== rtl/core/wlru_wmark.sv =====
// ----------------------------------------------------------------------------
// wlru_wmark
// Low watermark: max(1, floor(max_size * min(fraction, 256) / 256)), registered.
// ----------------------------------------------------------------------------
module wlru_wmark import wlru_pkg::*; (
  input  logic               clk_i,
  input  logic [MaxW-1:0]    max_size_i,
  input  logic [FracW-1:0]   frac_i,
  output logic [MaxW-1:0]    wmark_o
);

  logic [FracW-1:0]      frac_sat;
  logic [MaxW+FracW-1:0] prod;
  logic [MaxW-1:0]       wmark_d, wmark_q;

  assign frac_sat = (frac_i > FracFull) ? FracFull : frac_i;
  assign prod     = (MaxW+FracW)'(max_size_i) * (MaxW+FracW)'(frac_sat);
  assign wmark_d  = (prod[MaxW+7:8] == '0) ? MaxW'(1) : prod[MaxW+7:8];

  always_ff @(posedge clk_i) begin
    wmark_q <= wmark_d;
  end

  assign wmark_o = wmark_q;

endmodule

// ===== rtl/core/weighted_lru_cache_evictor.sv =====
// command flow: update or remove scans the recency list at one entry per cycle, then
// shifts the younger entries down one per cycle
// eviction pass: one evicted beat per cycle unless the output stalls, after a read state
// throughput: one command at a time, the next is taken once the last beat is registered
// reset: table empty, weight zero, max_size 1024, clean_fraction 192; no clearing pass
// ----------------------------------------------------------------------------
// weighted_lru_cache_evictor
// Weighted lru table of directory keys with low watermark eviction, kept as a
// circular recency list in a single-port-write memory (head = least recent).
// ----------------------------------------------------------------------------
module weighted_lru_cache_evictor import wlru_pkg::*; #(
  parameter int unsigned Entries = DefEntries
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [MaxW-1:0]    cfg_data_i,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [47:0]        s_axis_tdata_i,   // dir_key, entry_count
  input  logic [1:0]         s_axis_tuser_i,   // command
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [71:0]        m_axis_tdata_o,   // key_out, freed_entries, total_weight
  output logic [2:0]         m_axis_tuser_o,   // status
  output logic               m_axis_tlast_o
);

  localparam int unsigned AW = $clog2(Entries);
  localparam int unsigned CW = $clog2(Entries + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned EW = KeyW + CountW;
  localparam logic [CW-1:0] FullCnt = CW'(Entries);
  localparam logic [SW-1:0] WrapS   = SW'(Entries);
  localparam logic [AW-1:0] LastIdx = AW'(Entries - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_EVF_RD, S_EVF, S_STORE, S_STORED, S_PASS_RD, S_PASS, S_ONE
  } state_e;

  function automatic logic [AW-1:0] phys(logic [AW-1:0] h, logic [CW-1:0] p);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(p);
    if (s >= WrapS) s = s - WrapS;
    return s[AW-1:0];
  endfunction

  state_e state_d, state_q;
  cmd_e   cmd_d, cmd_q;
  logic [KeyW-1:0]    key_d, key_q;
  logic [CountW-1:0]  cnt_d, cnt_q;
  logic               hit_d, hit_q;
  logic [CW-1:0]      scan_d, scan_q, cmp_d, cmp_q, shr_d, shr_q, wrp_d, wrp_q;
  logic               rdp_d, rdp_q, wpend_d, wpend_q;
  logic [AW-1:0]      head_d, head_q;
  logic [CW-1:0]      used_d, used_q;
  logic [WeightW-1:0] weight_d, weight_q;
  status_e            one_st_d, one_st_q;
  logic [KeyW-1:0]    one_key_d, one_key_q;
  logic [CountW-1:0]  one_freed_d, one_freed_q;
  logic               out_vld_d, out_vld_q;
  status_e            out_st_d, out_st_q;
  logic [KeyW-1:0]    out_key_d, out_key_q;
  logic [CountW-1:0]  out_freed_d, out_freed_q;
  logic [WeightW-1:0] out_wt_d, out_wt_q;
  logic               out_last_d, out_last_q;
  logic [MaxW-1:0]    max_q;
  logic [FracW-1:0]   frac_q;
  logic [MaxW-1:0]    wmark;

  logic [EW-1:0]      mem_q [Entries];
  logic [EW-1:0]      rd_data_q;
  logic [AW-1:0]      ra, wa;
  logic               we;
  logic [EW-1:0]      wd;
  logic [KeyW-1:0]    rd_key;
  logic [CountW-1:0]  rd_cnt;
  logic               can_emit, pass_now, done;
  logic [WeightW-1:0] nw, wm17;
  logic [CW-1:0]      nu;
  logic [AW-1:0]      head_nx;

  wlru_wmark u_wmark (
    .clk_i      (clk_i),
    .max_size_i (max_q),
    .frac_i     (frac_q),
    .wmark_o    (wmark)
  );

  assign rd_key   = rd_data_q[KeyW-1:0];
  assign rd_cnt   = rd_data_q[EW-1:KeyW];
  assign can_emit = !out_vld_q || m_axis_tready_i;
  assign wm17     = WeightW'(wmark);
  assign pass_now = (weight_q > WeightW'(max_q)) && (used_q != '0)
                    && (weight_q != WeightW'(1));
  assign head_nx  = (head_q == LastIdx) ? '0 : head_q + AW'(1);
  assign nw       = weight_q - WeightW'(1) - WeightW'(rd_cnt);
  assign nu       = used_q - CW'(1);
  assign done     = !((nw > wm17) && (nu != '0));

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_data_q <= mem_q[ra];
  end

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; key_d = key_q; cnt_d = cnt_q; hit_d = hit_q;
    scan_d = scan_q; cmp_d = cmp_q; shr_d = shr_q; wrp_d = wrp_q;
    rdp_d = rdp_q; wpend_d = wpend_q; head_d = head_q; used_d = used_q;
    weight_d = weight_q;
    one_st_d = one_st_q; one_key_d = one_key_q; one_freed_d = one_freed_q;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    out_st_d = out_st_q; out_key_d = out_key_q; out_freed_d = out_freed_q;
    out_wt_d = out_wt_q; out_last_d = out_last_q;
    ra = head_q; we = 1'b0; wa = head_q; wd = {cnt_q, key_q};

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d   = cmd_e'(s_axis_tuser_i);
          key_d   = s_axis_tdata_i[KeyW-1:0];
          cnt_d   = s_axis_tdata_i[EW-1:KeyW];
          hit_d   = 1'b0;
          scan_d  = '0;
          rdp_d   = 1'b0;
          one_key_d   = s_axis_tdata_i[KeyW-1:0];
          one_freed_d = '0;
          unique case (cmd_e'(s_axis_tuser_i))
            CMD_UPDATE: begin
              if (WeightW'(s_axis_tdata_i[EW-1:KeyW]) + WeightW'(1) > WeightW'(max_q)) begin
                one_st_d = ST_REJECTED;
                state_d  = S_ONE;
              end else if (used_q == '0) begin
                state_d = S_STORE;
              end else begin
                state_d = S_SCAN;
              end
            end
            CMD_REMOVE: begin
              if (used_q == '0) begin
                one_st_d = ST_ABSENT;
                state_d  = S_ONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            CMD_TRIM: begin
              one_st_d  = ST_TRIMMED;
              one_key_d = '0;
              state_d   = pass_now ? S_PASS_RD : S_ONE;
            end
            CMD_RSVD: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_q < used_q) ra = phys(head_q, scan_q);
        rdp_d  = scan_q < used_q;
        cmp_d  = scan_q;
        scan_d = scan_q + CW'(1);
        if (rdp_q && rd_key == key_q) begin
          rdp_d   = 1'b0;
          hit_d   = 1'b1;
          shr_d   = cmp_q + CW'(1);
          wpend_d = 1'b0;
          if (cmd_q == CMD_UPDATE) begin
            weight_d = weight_q + WeightW'(cnt_q) - WeightW'(rd_cnt);
          end else begin
            weight_d    = nw;
            one_st_d    = ST_REMOVED;
            one_freed_d = rd_cnt;
          end
          state_d = S_SHIFT;
        end else if (rdp_q && cmp_q == nu) begin
          rdp_d = 1'b0;
          if (cmd_q == CMD_REMOVE) begin
            one_st_d = ST_ABSENT;
            state_d  = S_ONE;
          end else begin
            state_d = (used_q == FullCnt) ? S_EVF_RD : S_STORE;
          end
        end
      end
      S_SHIFT: begin
        // pull each younger entry down one place, read then write in the cycle after
        if (shr_q < used_q) begin
          ra    = phys(head_q, shr_q);
          shr_d = shr_q + CW'(1);
        end
        wpend_d = shr_q < used_q;
        wrp_d   = shr_q - CW'(1);
        if (wpend_q) begin
          we = 1'b1;
          wa = phys(head_q, wrp_q);
          wd = rd_data_q;
        end
        if (shr_q >= used_q && !wpend_q) begin
          used_d  = nu;
          state_d = (cmd_q == CMD_UPDATE) ? S_STORE : S_ONE;
        end
      end
      S_EVF_RD: state_d = S_EVF;
      S_EVF: begin
        if (can_emit) begin
          out_vld_d = 1'b1; out_st_d = ST_EVICTED; out_key_d = rd_key;
          out_freed_d = rd_cnt; out_wt_d = nw; out_last_d = 1'b0;
          weight_d = nw;
          used_d   = nu;
          head_d   = head_nx;
          state_d  = S_STORE;
        end
      end
      S_STORE: begin
        we     = 1'b1;
        wa     = phys(head_q, used_q);
        used_d = used_q + CW'(1);
        if (!hit_q) weight_d = weight_q + WeightW'(1) + WeightW'(cnt_q);
        state_d = S_STORED;
      end
      S_STORED: begin
        // the stored beat is dropped when its own pass will evict it
        if (pass_now && (WeightW'(cnt_q) + WeightW'(1) > wm17)) begin
          state_d = S_PASS_RD;
        end else if (can_emit) begin
          out_vld_d = 1'b1; out_st_d = ST_STORED; out_key_d = key_q;
          out_freed_d = '0; out_wt_d = weight_q; out_last_d = !pass_now;
          state_d = pass_now ? S_PASS_RD : S_IDLE;
        end
      end
      S_PASS_RD: state_d = S_PASS;
      S_PASS: begin
        if (can_emit) begin
          ra = phys(head_q, CW'(1));
          out_vld_d = 1'b1; out_st_d = ST_EVICTED; out_key_d = rd_key;
          out_freed_d = rd_cnt; out_wt_d = nw;
          out_last_d = done && (cmd_q != CMD_TRIM);
          weight_d = nw;
          used_d   = nu;
          head_d   = head_nx;
          if (done) state_d = (cmd_q == CMD_TRIM) ? S_ONE : S_IDLE;
        end
      end
      S_ONE: begin
        if (can_emit) begin
          out_vld_d = 1'b1; out_st_d = one_st_q; out_key_d = one_key_q;
          out_freed_d = one_freed_q; out_wt_d = weight_q; out_last_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rdp_q     <= 1'b0;
      wpend_q   <= 1'b0;
      head_q    <= '0;
      used_q    <= '0;
      weight_q  <= '0;
      out_vld_q <= 1'b0;
      max_q     <= MaxSizeRst;
      frac_q    <= FracRst;
    end else begin
      state_q   <= state_d;
      rdp_q     <= rdp_d;
      wpend_q   <= wpend_d;
      head_q    <= head_d;
      used_q    <= used_d;
      weight_q  <= weight_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_MAX_SIZE:   max_q  <= cfg_data_i;
          CFG_CLEAN_FRAC: frac_q <= cfg_data_i[FracW-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; key_q <= key_d; cnt_q <= cnt_d; hit_q <= hit_d;
    scan_q <= scan_d; cmp_q <= cmp_d; shr_q <= shr_d; wrp_q <= wrp_d;
    one_st_q <= one_st_d; one_key_q <= one_key_d; one_freed_q <= one_freed_d;
    out_st_q <= out_st_d; out_key_q <= out_key_d; out_freed_q <= out_freed_d;
    out_wt_q <= out_wt_d; out_last_q <= out_last_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'd0, out_wt_q, out_freed_q, out_key_q};
  assign m_axis_tuser_o  = out_st_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== rtl/core/wlru_chk.sv =====
// ----------------------------------------------------------------------------
// wlru_chk
// Port-level checks of the weighted lru cache evictor, bound to the top level.
// ----------------------------------------------------------------------------
module wlru_chk import wlru_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // a stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
    && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("stalled output beat changed");

  // a command still producing beats takes no new input
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input taken mid-command");

  // single-beat results always close their command
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_REJECTED || m_axis_tuser_o == ST_REMOVED
    || m_axis_tuser_o == ST_ABSENT || m_axis_tuser_o == ST_TRIMMED) |-> m_axis_tlast_o)
    else $error("single result without last");

  // a real command occupies the block
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i != CMD_RSVD |=> !s_axis_tready_o)
    else $error("ready stayed high after a command");

endmodule

bind weighted_lru_cache_evictor wlru_chk u_wlru_chk (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Random and directed stimulus for the weighted lru cache evictor, with a
// scoreboard that tracks the table contents and predicts every output beat.
// ----------------------------------------------------------------------------
module tb_top;
  import wlru_pkg::*;

  localparam int NumSlots = 16;

  typedef struct packed {
    status_e            st;
    logic [KeyW-1:0]    key;
    logic [CountW-1:0]  freed;
    logic [WeightW-1:0] weight;
    logic               last;
  } evict_beat_t;

  class lru_scoreboard;
    logic              valid_q[NumSlots];
    logic [KeyW-1:0]   key_q[NumSlots];
    logic [CountW-1:0] count_q[NumSlots];
    int unsigned       rank_q[NumSlots];
    int unsigned       weight_sum;
    int unsigned       used;
    int unsigned       max_size;
    int unsigned       clean_frac;
    evict_beat_t       pending_q[$];
    int                n_errors;

    function new();
      for (int i = 0; i < NumSlots; i++) begin
        valid_q[i] = 1'b0;
        rank_q[i] = 0;
      end
      weight_sum = 0;
      used = 0;
      max_size = 1024;
      clean_frac = 192;
      n_errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, int unsigned v);
      if (idx == CFG_MAX_SIZE) max_size = v & 16'hffff;
      else clean_frac = v & 9'h1ff;
    endfunction

    function void push(status_e st, logic [KeyW-1:0] k, logic [CountW-1:0] f);
      evict_beat_t b;
      b.st = st;
      b.key = k;
      b.freed = f;
      b.weight = weight_sum[WeightW-1:0];
      b.last = 1'b0;
      pending_q.insert(pending_q.size(), b);
    endfunction

    function void drop(int s);
      weight_sum -= 1 + count_q[s];
      valid_q[s] = 1'b0;
      for (int i = 0; i < NumSlots; i++)
        if (valid_q[i] && rank_q[i] > rank_q[s]) rank_q[i]--;
      used--;
    endfunction

    function int oldest_slot();
      for (int i = 0; i < NumSlots; i++)
        if (valid_q[i] && rank_q[i] == 0) return i;
      return -1;
    endfunction

    function int unsigned low_mark();
      int unsigned f;
      int unsigned m;
      f = (clean_frac > 256) ? 256 : clean_frac;
      m = (max_size * f) >> 8;
      return (m == 0) ? 1 : m;
    endfunction

    function bit over_limit();
      return weight_sum > max_size && used > 0 && weight_sum != 1;
    endfunction

    function void evict_to_mark();
      int unsigned lim;
      int s;
      if (!over_limit()) return;
      lim = low_mark();
      while (weight_sum > lim && used > 0) begin
        s = oldest_slot();
        if (s < 0) break;
        drop(s);
        push(ST_EVICTED, key_q[s], count_q[s]);
      end
    endfunction

    function int find(logic [KeyW-1:0] k);
      for (int i = 0; i < NumSlots; i++)
        if (valid_q[i] && key_q[i] == k) return i;
      return -1;
    endfunction

    // predict every beat caused by one accepted command
    function void note_command(cmd_e cmd, logic [KeyW-1:0] k, logic [CountW-1:0] c);
      int s;
      int v;
      int n0;
      n0 = pending_q.size();
      if (cmd == CMD_UPDATE) begin
        if (c + 1 > max_size) begin
          push(ST_REJECTED, k, '0);
        end else begin
          s = find(k);
          if (s < 0) begin
            if (used >= NumSlots) begin
              v = oldest_slot();
              if (v >= 0) begin
                drop(v);
                push(ST_EVICTED, key_q[v], count_q[v]);
              end
            end
            for (int i = 0; i < NumSlots; i++)
              if (!valid_q[i] && s < 0) s = i;
            valid_q[s] = 1'b1;
            key_q[s] = k;
            count_q[s] = '0;
            rank_q[s] = used;
            used++;
            weight_sum += 1;
          end
          weight_sum = weight_sum - count_q[s] + c;
          count_q[s] = c;
          for (int i = 0; i < NumSlots; i++)
            if (valid_q[i] && rank_q[i] > rank_q[s]) rank_q[i]--;
          rank_q[s] = used - 1;
          // stored beat left out when the new key itself goes in the pass
          if (!(over_limit() && 1 + c > low_mark())) push(ST_STORED, k, '0);
          evict_to_mark();
        end
      end else if (cmd == CMD_REMOVE) begin
        s = find(k);
        if (s < 0) push(ST_ABSENT, k, '0);
        else begin
          drop(s);
          push(ST_REMOVED, k, count_q[s]);
        end
      end else if (cmd == CMD_TRIM) begin
        evict_to_mark();
        push(ST_TRIMMED, '0, '0);
      end
      if (pending_q.size() > n0) pending_q[pending_q.size()-1].last = 1'b1;
    endfunction

    function void check_beat(evict_beat_t got);
      evict_beat_t exp_b;
      if (pending_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected beat %p", got);
        return;
      end
      exp_b = pending_q.pop_front();
      if (got !== exp_b) begin
        n_errors++;
        if (n_errors <= 10) $display("mismatch: expected %p got %p", exp_b, got);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [MaxW-1:0]    cfg_data_i;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [47:0]        s_axis_tdata_i;   // dir_key, entry_count
  logic [1:0]         s_axis_tuser_i;   // command
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [71:0]        m_axis_tdata_o;   // key_out, freed_entries, total_weight
  logic [2:0]         m_axis_tuser_o;   // status
  logic               m_axis_tlast_o;

  lru_scoreboard sb;
  int unsigned   cycle_cnt;
  logic [KeyW-1:0] key_pool[8];
  bit            stall_on;

  weighted_lru_cache_evictor uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver stalls on its own pattern: quiet stretches, then random
  always @(negedge clk_i) begin
    if (!stall_on) m_axis_tready_i <= 1'b1;
    else m_axis_tready_i <= ($urandom_range(0, 2) != 0);
  end

  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
  end

  always @(posedge clk_i) begin
    evict_beat_t b;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      b.st = status_e'(m_axis_tuser_o);
      b.key = m_axis_tdata_o[31:0];
      b.freed = m_axis_tdata_o[47:32];
      b.weight = m_axis_tdata_o[64:48];
      b.last = m_axis_tlast_o;
      sb.check_beat(b);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_cmd(cmd_e cmd, logic [KeyW-1:0] k, logic [CountW-1:0] c);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= cmd;
    s_axis_tdata_i <= {c, k};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_command(cmd, k, c);
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(int n);
    s_axis_tvalid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    // block may still be busy with the final beat registered
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [MaxW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_phase(int n);
    int burst;
    int sent;
    cmd_e cmd;
    logic [KeyW-1:0] k;
    logic [CountW-1:0] c;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst && sent < n; j++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: cmd = CMD_UPDATE;
          11, 12, 13, 14: cmd = CMD_REMOVE;
          15, 16: cmd = CMD_TRIM;
          17: cmd = CMD_RSVD;
          default: cmd = CMD_UPDATE;
        endcase
        k = ($urandom_range(0, 3) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
        case ($urandom_range(0, 3))
          0: c = CountW'($urandom());
          1: c = CountW'($urandom_range(0, 15));
          default: c = CountW'($urandom_range(0, 300));
        endcase
        send_cmd(cmd, k, c);
        if (cmd != CMD_RSVD) sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 20));
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_MAX_SIZE;
    cfg_data_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = CMD_UPDATE;
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, every command, full table, own eviction, rejection
    send_cmd(CMD_REMOVE, 32'h0, 16'h0);
    send_cmd(CMD_TRIM, 32'hffff_ffff, 16'hffff);
    send_cmd(CMD_UPDATE, 32'h0, 16'h0);
    send_cmd(CMD_UPDATE, 32'hffff_ffff, 16'd1023);
    send_cmd(CMD_UPDATE, 32'h1234_5678, 16'hffff);
    send_cmd(CMD_RSVD, 32'h5555_aaaa, 16'h5555);
    for (int i = 0; i < 17; i++) send_cmd(CMD_UPDATE, 32'h100 + i, 16'd3);
    send_cmd(CMD_UPDATE, 32'h105, 16'd1000);
    send_cmd(CMD_REMOVE, 32'h10a, 16'd0);
    drain();

    write_reg(CFG_MAX_SIZE, 16'd100);
    write_reg(CFG_CLEAN_FRAC, 9'd256);
    send_cmd(CMD_TRIM, 32'h0, 16'h0);
    random_phase(60);
    drain();

    write_reg(CFG_MAX_SIZE, 16'd1);
    write_reg(CFG_CLEAN_FRAC, 9'd0);
    send_cmd(CMD_UPDATE, 32'hdead_beef, 16'd0);
    send_cmd(CMD_UPDATE, 32'hdead_beef, 16'd1);
    send_cmd(CMD_TRIM, 32'h0, 16'h0);
    random_phase(50);
    drain();

    write_reg(CFG_MAX_SIZE, 16'd0);
    random_phase(20);
    drain();

    write_reg(CFG_MAX_SIZE, 16'hffff);
    write_reg(CFG_CLEAN_FRAC, 9'h1ff);
    random_phase(60);
    drain();

    write_reg(CFG_MAX_SIZE, 16'd400);
    write_reg(CFG_CLEAN_FRAC, 9'd128);
    send_cmd(CMD_TRIM, 32'h0, 16'h0);
    random_phase(100);
    drain();

    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
